// ===== rtl/stream_deduplicator_macros.svh =====
// Assertion macros for the stream deduplicator.
// Bodies use clk and rst_n of the including module.
`ifndef STREAM_DEDUPLICATOR_MACROS_SVH
`define STREAM_DEDUPLICATOR_MACROS_SVH

// cond must hold at every edge out of reset
`define SDD_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// b must hold in the same cycle as a
`define SDD_ASSERT_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// b must hold in the cycle after a
`define SDD_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/sdedup_pkg.sv =====
// Package for the stream deduplicator: sizes, widths, FSM state type
// and the command/status structs between controller and datapath.
package sdedup_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

  localparam int SAMPLE_W = 32;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic advance;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic exhausted;
    logic match;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/sdedup_if.sv =====
// Handshake channel interfaces for input items and result items.
// Depends on sdedup_pkg for payload widths.
interface sdedup_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdedup_pkg::SAMPLE_W-1:0] sample_value;
  logic                               end_of_set;

  modport source (output valid, output sample_value, output end_of_set, input ready);
  modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface sdedup_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   first_seen;
  logic signed [sdedup_pkg::SAMPLE_W-1:0] echoed_value;
  logic        [sdedup_pkg::SLOT_W-1:0]   slot_index;
  logic        [sdedup_pkg::COUNT_W-1:0]  distinct_count;
  logic                                   table_overflow;
  logic                                   set_finished;

  modport source (output valid, output first_seen, output echoed_value, output slot_index,
                  output distinct_count, output table_overflow, output set_finished,
                  input ready);
  modport sink   (input valid, input first_seen, input echoed_value, input slot_index,
                  input distinct_count, input table_overflow, input set_finished,
                  output ready);
endinterface

// ===== rtl/stream_deduplicator.sv =====
// Stream deduplicator top level: controller plus datapath.
// Depends on sdedup_pkg, sdedup_if, sdedup_ctrl, sdedup_dp and the macros header.
//
// in_chan carries one signed sample_value and an end_of_set flag per item;
// out_chan returns exactly one result per item: first_seen, echoed_value,
// slot_index, distinct_count, table_overflow and set_finished.
// The item is checked against the distinct values of the current set held
// in a TABLE_DEPTH-entry memory; one comparator reads one entry per cycle.
// Each item is accepted, then scanned entry by entry until a match or the
// end of the stored entries (a new value compares all n stored entries),
// then handed to the output register; only then is the next item accepted.
// The memory read port (one entry a cycle) sets the scan rate.
// A result waits in the output register while the next item is accepted
// and scanned; a stalled receiver holds the block once a second result
// is ready. end_of_set clears the count after its result.
// Reset (rst_n low, synchronous) empties the set and drops any pending
// result; the table memory itself needs no clearing.
`include "stream_deduplicator_macros.svh"

module stream_deduplicator (
  input  logic         clk,
  input  logic         rst_n,
  sdedup_in_if.sink    in_chan,
  sdedup_out_if.source out_chan
);

  sdedup_pkg::cmd_t    cmd;
  sdedup_pkg::status_t sts;
  logic                in_ready;

  assign in_chan.ready = in_ready;

  sdedup_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdedup_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_value (in_chan.sample_value),
    .in_end_of_set   (in_chan.end_of_set),
    .out_chan        (out_chan)
  );

  `SDD_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.start, cmd.advance, cmd.decide, cmd.emit}))
  `SDD_ASSERT_IMPLY(a_emit_free, cmd.emit, sts.out_free)
  `SDD_ASSERT_NEXT(a_busy_after_start, cmd.start, !in_ready)

endmodule

// ===== rtl/sdedup_dp.sv =====
// Datapath: value table memory, stored count, scan pointer, comparator,
// result and output registers. Depends on sdedup_pkg and sdedup_if.
module sdedup_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sdedup_pkg::cmd_t                       cmd,
  output sdedup_pkg::status_t                    sts,
  input  logic signed [sdedup_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                   in_end_of_set,
  sdedup_out_if.source                           out_chan
);

  logic [sdedup_pkg::VALUE_WIDTH-1:0] mem [sdedup_pkg::TABLE_DEPTH];
  logic [sdedup_pkg::VALUE_WIDTH-1:0] rd_data_r;
  logic [sdedup_pkg::IDX_W-1:0]       rd_addr;
  logic                               wr_en;

  logic [sdedup_pkg::VALUE_WIDTH-1:0] key_r;
  logic [sdedup_pkg::SAMPLE_W-1:0]    raw_r;
  logic                               last_r;

  logic [sdedup_pkg::CNT_W-1:0] cmp_idx_r, cmp_idx_nxt, cmp_idx_inc;
  logic [sdedup_pkg::CNT_W-1:0] count_r, count_nxt, count_new;

  logic                         hit, full;
  logic                         res_fresh_r, res_over_r;
  logic [sdedup_pkg::CNT_W-1:0] res_slot_r, res_cnt_r;
  logic                         out_valid_r;

  assign cmp_idx_inc = cmp_idx_r + sdedup_pkg::CNT_W'(1);
  assign rd_addr     = cmd.advance ? cmp_idx_inc[sdedup_pkg::IDX_W-1:0]
                                   : cmp_idx_r[sdedup_pkg::IDX_W-1:0];

  assign sts.exhausted = (cmp_idx_r == count_r);
  assign sts.match     = (rd_data_r == key_r);
  assign sts.out_free  = !out_valid_r || out_chan.ready;

  assign hit   = !sts.exhausted && sts.match;
  assign full  = (count_r == sdedup_pkg::CNT_W'(sdedup_pkg::TABLE_DEPTH));
  assign wr_en = cmd.decide && !hit && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[sdedup_pkg::IDX_W-1:0]] <= key_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    cmp_idx_nxt = cmp_idx_r;
    if (cmd.advance) begin
      cmp_idx_nxt = cmp_idx_inc;
    end else if (cmd.decide || cmd.start) begin
      cmp_idx_nxt = '0;
    end
  end

  assign count_new = wr_en ? cmp_idx_inc : count_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.decide) begin
      count_nxt = last_r ? '0 : count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_idx_r <= cmp_idx_nxt;
      count_r   <= count_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r  <= in_sample_value[sdedup_pkg::VALUE_WIDTH-1:0];
      raw_r  <= in_sample_value;
      last_r <= in_end_of_set;
    end
    if (cmd.decide) begin
      res_fresh_r <= wr_en;
      res_over_r  <= !hit && full;
      res_cnt_r   <= count_new;
      if (hit) begin
        res_slot_r <= cmp_idx_r;
      end else if (full) begin
        res_slot_r <= '0;
      end else begin
        res_slot_r <= count_r;
      end
    end
    if (cmd.emit) begin
      out_chan.first_seen     <= res_fresh_r;
      out_chan.echoed_value   <= raw_r;
      out_chan.slot_index     <= sdedup_pkg::SLOT_W'(res_slot_r);
      out_chan.distinct_count <= sdedup_pkg::COUNT_W'(res_cnt_r);
      out_chan.table_overflow <= res_over_r;
      out_chan.set_finished   <= last_r;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule

// ===== rtl/sdedup_ctrl.sv =====
// Controller FSM: accepts an item, steps the table scan, hands the
// result to the output register. Depends on sdedup_pkg.
module sdedup_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdedup_pkg::status_t sts,
  output sdedup_pkg::cmd_t    cmd
);

  sdedup_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdedup_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sdedup_pkg::ST_SCAN;
      end
      sdedup_pkg::ST_SCAN: begin
        if (sts.exhausted || sts.match) state_nxt = sdedup_pkg::ST_EMIT;
      end
      sdedup_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = sdedup_pkg::ST_IDLE;
      end
      default: state_nxt = sdedup_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      sdedup_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      sdedup_pkg::ST_SCAN: begin
        cmd.advance = !sts.exhausted && !sts.match;
        cmd.decide  = sts.exhausted || sts.match;
      end
      sdedup_pkg::ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdedup_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
